FILE: src/point_clamp_to_circle_or_box_unit_macros.svh
// Assertion macros for the point clamp unit checker.
`ifndef POINT_CLAMP_TO_CIRCLE_OR_BOX_UNIT_MACROS_SVH
`define POINT_CLAMP_TO_CIRCLE_OR_BOX_UNIT_MACROS_SVH

// checked only out of reset
`define PCB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked during reset too
`define PCB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: src/pcb_pkg.sv
// Shared constants and register codes for the point clamp unit.
package pcb_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int SQ_W       = 30;  // magnitude width fed to the squarer
  localparam int RAD_W      = 62;  // normalized squared length width
  localparam int ROOT_W     = 31;  // square root width
  localparam int F_W        = 5;   // normalize shift count width
  localparam int NORM_STEPS = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_HALF_X      = 3'd2,
    REG_HALF_Y      = 3'd3,
    REG_SQUARE_MODE = 3'd4
  } cfg_reg_e;

endpackage

FILE: src/pcb_if.sv
// Channel interfaces: point input, placed output, configuration writes.
interface pcb_point_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] point_x;
  logic signed [W-1:0] point_y;
  modport source (output valid, point_x, point_y, input ready);
  modport sink   (input valid, point_x, point_y, output ready);
endinterface

interface pcb_place_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] placed_x;
  logic signed [W-1:0] placed_y;
  logic                inside_res;
  modport source (output valid, placed_x, placed_y, inside_res, input ready);
  modport sink   (input valid, placed_x, placed_y, inside_res, output ready);
endinterface

interface pcb_cfg_if #(parameter int W = 16);
  logic                          valid;
  logic                          ready;
  logic [pcb_pkg::CFG_IDX_W-1:0] index;
  logic [W-1:0]                  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/pcb_delay.sv
// Enabled delay line for sideband data.
module pcb_delay #(
  parameter int DW    = 8,
  parameter int DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [DW-1:0] d_i,
  output logic [DW-1:0] q_o
);

  logic [DW-1:0] stg_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stg_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        stg_q[i] <= stg_q[i-1];
      end
    end
  end

  assign q_o = stg_q[DEPTH-1];

endmodule

FILE: src/pcb_isqrt.sv
// Pipelined integer square root, two radicand bits per stage.
module pcb_isqrt #(
  parameter int DW = 62
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [DW-1:0]   rad_i,
  output logic [DW/2-1:0] root_o
);

  localparam int N  = DW / 2;
  localparam int RW = N + 3;

  logic [RW-1:0] rem_q  [N];
  logic [N-1:0]  root_q [N];
  logic [DW-1:0] rest_q [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [RW-1:0] rem_in, rem_n, trial;
    logic [N-1:0]  root_in;
    logic [DW-1:0] rest_in;
    logic          ge;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rest_in = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign rest_in = rest_q[i-1];
    end

    assign rem_n = {rem_in[RW-3:0], rest_in[DW-1:DW-2]};
    assign trial = RW'({root_in, 2'b01});
    assign ge    = rem_n >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= ge ? (rem_n - trial) : rem_n;
        root_q[i] <= {root_in[N-2:0], ge};
        rest_q[i] <= rest_in << 2;
      end
    end
  end

  assign root_o = root_q[N-1];

endmodule

FILE: src/pcb_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module pcb_div #(
  parameter int NB = 32,
  parameter int DB = 16,
  parameter int QB = 16
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NB-1:0] num_i,
  input  logic [DB-1:0] den_i,
  output logic [QB-1:0] quo_o
);

  logic [DB-1:0] rem_q [QB];
  logic [QB-1:0] low_q [QB];
  logic [QB-1:0] quo_q [QB];
  logic [DB-1:0] den_q [QB];

  for (genvar i = 0; i < QB; i++) begin : g_stage
    logic [DB-1:0] rem_in, den_in;
    logic [QB-1:0] low_in, quo_in;
    logic [DB:0]   rem_n, diff;
    logic          ge;

    if (i == 0) begin : g_first
      // upper numerator bits start below the divisor for valid operands
      assign rem_in = num_i[NB-1:QB];
      assign low_in = num_i[QB-1:0];
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign low_in = low_q[i-1];
      assign quo_in = quo_q[i-1];
      assign den_in = den_q[i-1];
    end

    assign rem_n = {rem_in, low_in[QB-1]};
    assign ge    = rem_n >= {1'b0, den_in};
    assign diff  = rem_n - {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= ge ? diff[DB-1:0] : rem_n[DB-1:0];
        low_q[i] <= low_in << 1;
        quo_q[i] <= {quo_in[QB-2:0], ge};
        den_q[i] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[QB-1];

endmodule

FILE: src/point_clamp_to_circle_or_box_unit.sv
// Top level: places points relative to a configured box or circle.
//
// Usage:
//   cfg_i   : register writes (index, data), always ready. Registers are
//             center_x, center_y, half_x, half_y, square_mode. Write only
//             while no point is in flight. Unknown indexes are ignored.
//   point_i : one point per transaction, signed Q12.4 coordinates.
//   place_o : one placed point plus inside flag per input transaction.
// Throughput: one point per cycle while the output is not stalled, with no bubbles.
// Pipeline depth: set by the 31-stage square root unit, five normalize stages
//   and the COORD_BITS-stage divider pair, plus front and output registers.
// Stall: the whole pipeline freezes while the output holds an untaken
//   result; point_i.ready is low only then.
// Reset: configuration registers and valid bits clear (data registers are not
//   reset); the pipeline is empty and ready on leaving reset.
module point_clamp_to_circle_or_box_unit #(
  parameter int COORD_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  pcb_cfg_if.sink             cfg_i,
  pcb_point_if.sink           point_i,
  pcb_place_if.source         place_o
);

  localparam int W     = COORD_BITS;
  localparam int HW    = W - 1;
  localparam int PW    = W + HW;
  localparam int SQW   = pcb_pkg::SQ_W;
  localparam int RADW  = pcb_pkg::RAD_W;
  localparam int ROOTW = pcb_pkg::ROOT_W;
  localparam int FW    = pcb_pkg::F_W;
  localparam int NSTEP = pcb_pkg::NORM_STEPS;
  localparam int ISQN  = RADW / 2;
  localparam int NCW   = ROOTW + HW;
  localparam int NB    = (2 * W > W + ROOTW + 1) ? 2 * W : W + ROOTW + 1;
  localparam int DB    = NB - W;
  localparam int QB    = W;
  localparam int NST   = 45 + W;
  localparam int SBW   = 2 * PW + W + 3 + 2 * SQW + 2 + 2 * (W + 1);
  localparam int SSW   = 5 + 2 * (W + 1);

  // ---------------- configuration ----------------
  logic signed [W-1:0] center_x_q, center_y_q;
  logic [HW-1:0]       half_x_q, half_y_q;
  logic                square_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      half_x_q   <= '0;
      half_y_q   <= '0;
      square_q   <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        pcb_pkg::REG_CENTER_X:    center_x_q <= cfg_i.data;
        pcb_pkg::REG_CENTER_Y:    center_y_q <= cfg_i.data;
        pcb_pkg::REG_HALF_X:      half_x_q   <= cfg_i.data[HW-1:0];
        pcb_pkg::REG_HALF_Y:      half_y_q   <= cfg_i.data[HW-1:0];
        pcb_pkg::REG_SQUARE_MODE: square_q   <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  logic [HW-1:0] rad;
  assign rad = (half_x_q < half_y_q) ? half_x_q : half_y_q;

  // ---------------- flow control ----------------
  logic           adv;
  logic [NST-1:0] vld_q;

  assign adv           = !place_o.valid || place_o.ready;
  assign point_i.ready = adv;
  assign place_o.valid = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], point_i.valid};
    end
  end

  // ---------------- F1: offsets ----------------
  logic signed [W:0] dx1_q, dy1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx1_q <= {point_i.point_x[W-1], point_i.point_x} - {center_x_q[W-1], center_x_q};
      dy1_q <= {point_i.point_y[W-1], point_i.point_y} - {center_y_q[W-1], center_y_q};
    end
  end

  // ---------------- F2: magnitudes ----------------
  logic [W:0]        absx, absy;
  logic [W-1:0]      ax2_q, ay2_q;
  logic signed [W:0] dx2_q, dy2_q;

  assign absx = dx1_q[W] ? (W+1)'(-dx1_q) : dx1_q;
  assign absy = dy1_q[W] ? (W+1)'(-dy1_q) : dy1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ax2_q <= absx[W-1:0];
      ay2_q <= absy[W-1:0];
      dx2_q <= dx1_q;
      dy2_q <= dy1_q;
    end
  end

  // ---------------- F3: products and flags ----------------
  logic [31:0]       ex, ey, eo, shx, shy;
  logic [PW-1:0]     pxhx3_q, pxhy3_q, pyhx3_q, pyhy3_q;
  logic [2*HW-1:0]   sqax3_q, sqay3_q, r2_3_q;
  logic [SQW-1:0]    sx3_q, sy3_q;
  logic [W-1:0]      ax3_q, ay3_q;
  logic              boxin3_q, over3_q, gt3_q;
  logic signed [W:0] dx3_q, dy3_q;

  assign ex = 32'(ax2_q);
  assign ey = 32'(ay2_q);
  assign eo = ex | ey;

  // keep both magnitudes below 2^30 ahead of the squarer
  always_comb begin
    priority if (eo[31]) begin
      shx = ex >> 2;
      shy = ey >> 2;
    end else if (eo[30]) begin
      shx = ex >> 1;
      shy = ey >> 1;
    end else begin
      shx = ex;
      shy = ey;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pxhx3_q  <= PW'(ax2_q) * PW'(half_x_q);
      pxhy3_q  <= PW'(ax2_q) * PW'(half_y_q);
      pyhx3_q  <= PW'(ay2_q) * PW'(half_x_q);
      pyhy3_q  <= PW'(ay2_q) * PW'(half_y_q);
      sqax3_q  <= (2*HW)'(ax2_q[HW-1:0]) * (2*HW)'(ax2_q[HW-1:0]);
      sqay3_q  <= (2*HW)'(ay2_q[HW-1:0]) * (2*HW)'(ay2_q[HW-1:0]);
      r2_3_q   <= (2*HW)'(rad) * (2*HW)'(rad);
      sx3_q    <= shx[SQW-1:0];
      sy3_q    <= shy[SQW-1:0];
      ax3_q    <= ax2_q;
      ay3_q    <= ay2_q;
      boxin3_q <= (ax2_q <= W'(half_x_q)) && (ay2_q <= W'(half_y_q));
      over3_q  <= ((half_x_q != '0) && (ax2_q > W'(half_x_q))) ||
                  ((half_y_q != '0) && (ay2_q > W'(half_y_q)));
      gt3_q    <= (ax2_q > W'(rad)) || (ay2_q > W'(rad));
      dx3_q    <= dx2_q;
      dy3_q    <= dy2_q;
    end
  end

  // ---------------- F4: dominant axis, squares ----------------
  logic              xdom;
  logic [PW-1:0]     numx4_q, numy4_q;
  logic [W-1:0]      bden4_q;
  logic              over4_q, cuse4_q, inside4_q;
  logic [2*SQW-1:0]  sxx4_q, syy4_q;
  logic [SQW-1:0]    sx4_q, sy4_q;
  logic signed [W:0] dx4_q, dy4_q;
  logic              incirc;

  always_comb begin
    priority if (half_x_q == '0) begin
      xdom = 1'b0;
    end else if (half_y_q == '0) begin
      xdom = ax3_q != '0;
    end else begin
      xdom = pxhy3_q > pyhx3_q;
    end
  end

  assign incirc = !gt3_q &&
                  (((2*HW+1)'(sqax3_q) + (2*HW+1)'(sqay3_q)) <= (2*HW+1)'(r2_3_q));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // dominant lane divides to exactly its half extent
      numx4_q   <= xdom ? pxhx3_q : pxhy3_q;
      numy4_q   <= xdom ? pyhx3_q : pyhy3_q;
      bden4_q   <= xdom ? ax3_q : ay3_q;
      over4_q   <= over3_q;
      cuse4_q   <= ((sx3_q | sy3_q) != '0) && (rad != '0);
      inside4_q <= square_q ? boxin3_q : incirc;
      sxx4_q    <= (2*SQW)'(sx3_q) * (2*SQW)'(sx3_q);
      syy4_q    <= (2*SQW)'(sy3_q) * (2*SQW)'(sy3_q);
      sx4_q     <= sx3_q;
      sy4_q     <= sy3_q;
      dx4_q     <= dx3_q;
      dy4_q     <= dy3_q;
    end
  end

  logic [SBW-1:0] sb4, sb40;

  assign sb4 = {numx4_q, numy4_q, bden4_q, over4_q, cuse4_q, inside4_q,
                sx4_q, sy4_q, dx4_q[W], dy4_q[W], dx4_q, dy4_q};

  pcb_delay #(.DW(SBW), .DEPTH(1 + NSTEP + ISQN)) u_sb_dly (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   (sb4),
    .q_o   (sb40)
  );

  // ---------------- F5: squared length ----------------
  logic [RADW-1:0] s5_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_q <= RADW'(sxx4_q) + RADW'(syy4_q);
    end
  end

  // ---------------- normalize into [2^60, 2^62) ----------------
  logic [RADW-1:0] nrm_s_q [NSTEP];
  logic [FW-1:0]   nrm_f_q [NSTEP];

  for (genvar j = 0; j < NSTEP; j++) begin : g_norm
    localparam int SH = 32 >> j;
    logic [RADW-1:0] s_in;
    logic [FW-1:0]   f_in;

    if (j == 0) begin : g_first
      assign s_in = s5_q;
      assign f_in = '0;
    end else begin : g_next
      assign s_in = nrm_s_q[j-1];
      assign f_in = nrm_f_q[j-1];
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (s_in[RADW-1 -: SH] == '0) begin
          nrm_s_q[j] <= s_in << SH;
          nrm_f_q[j] <= f_in + FW'(SH / 2);
        end else begin
          nrm_s_q[j] <= s_in;
          nrm_f_q[j] <= f_in;
        end
      end
    end
  end

  logic [ROOTW-1:0] root40;
  logic [FW-1:0]    f40;

  pcb_isqrt #(.DW(RADW)) u_isqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (nrm_s_q[NSTEP-1]),
    .root_o (root40)
  );

  pcb_delay #(.DW(FW), .DEPTH(ISQN)) u_f_dly (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   (nrm_f_q[NSTEP-1]),
    .q_o   (f40)
  );

  // ---------------- sideband unpack ----------------
  logic [PW-1:0]     u_numx, u_numy;
  logic [W-1:0]      u_bden;
  logic              u_over, u_cuse, u_inside, u_negx, u_negy;
  logic [SQW-1:0]    u_sx, u_sy;
  logic signed [W:0] u_dx, u_dy;

  logic [SBW-1:0] sb41_q, sb42_q;

  assign {u_numx, u_numy, u_bden, u_over, u_cuse, u_inside,
          u_sx, u_sy, u_negx, u_negy, u_dx, u_dy} = sb42_q;

  // ---------------- F42: scale offsets by 2^f ----------------
  logic [SQW-1:0]   s40_sx, s40_sy;
  logic [2*SQW:0]   tx, ty;
  logic [ROOTW-1:0] cx41_q, cy41_q, root41_q;

  assign s40_sx = sb40[2 + 2*(W+1) + SQW +: SQW];
  assign s40_sy = sb40[2 + 2*(W+1) +: SQW];
  assign tx     = (2*SQW+1)'(s40_sx) << f40;
  assign ty     = (2*SQW+1)'(s40_sy) << f40;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cx41_q   <= tx[ROOTW-1:0];
      cy41_q   <= ty[ROOTW-1:0];
      root41_q <= root40;
      sb41_q   <= sb40;
    end
  end

  // ---------------- F43: multiply by radius ----------------
  logic [NCW-1:0]   ncx42_q, ncy42_q;
  logic [ROOTW-1:0] root42_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ncx42_q  <= NCW'(cx41_q) * NCW'(rad);
      ncy42_q  <= NCW'(cy41_q) * NCW'(rad);
      root42_q <= root41_q;
      sb42_q   <= sb41_q;
    end
  end

  // ---------------- F44: rounding bias, operand select ----------------
  logic [NB-1:0]  numx43_q, numy43_q;
  logic [DB-1:0]  den43_q;
  logic [SSW-1:0] ss43_q, ss_out;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (square_q) begin
        numx43_q <= NB'(u_numx) + NB'(u_bden >> 1);
        numy43_q <= NB'(u_numy) + NB'(u_bden >> 1);
        den43_q  <= DB'(u_bden);
      end else begin
        numx43_q <= NB'(ncx42_q) + NB'(root42_q >> 1);
        numy43_q <= NB'(ncy42_q) + NB'(root42_q >> 1);
        den43_q  <= DB'(root42_q);
      end
      ss43_q <= {u_over, u_cuse, u_inside, u_negx, u_negy, u_dx, u_dy};
    end
  end

  logic [QB-1:0] qx, qy;

  pcb_div #(.NB(NB), .DB(DB), .QB(QB)) u_div_x (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (numx43_q),
    .den_i (den43_q),
    .quo_o (qx)
  );

  pcb_div #(.NB(NB), .DB(DB), .QB(QB)) u_div_y (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (numy43_q),
    .den_i (den43_q),
    .quo_o (qy)
  );

  pcb_delay #(.DW(SSW), .DEPTH(QB)) u_ss_dly (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   (ss43_q),
    .q_o   (ss_out)
  );

  // ---------------- output: apply sign, add center, saturate ----------------
  logic              o_over, o_cuse, o_inside, o_negx, o_negy;
  logic signed [W:0] o_dx, o_dy;
  logic signed [W+1:0] qxs, qys, offx, offy, sumx, sumy, sat_hi, sat_lo;
  logic signed [W-1:0] px_d, py_d;
  logic signed [W-1:0] placed_x_q, placed_y_q;
  logic                inside_q;

  assign {o_over, o_cuse, o_inside, o_negx, o_negy, o_dx, o_dy} = ss_out;

  assign qxs    = $signed({2'b00, qx});
  assign qys    = $signed({2'b00, qy});
  assign sat_hi = $signed({3'b000, {(W-1){1'b1}}});
  assign sat_lo = $signed({3'b111, {(W-1){1'b0}}});

  always_comb begin
    if (square_q) begin
      offx = o_over ? (o_negx ? -qxs : qxs) : {o_dx[W], o_dx};
      offy = o_over ? (o_negy ? -qys : qys) : {o_dy[W], o_dy};
    end else begin
      offx = o_cuse ? (o_negx ? -qxs : qxs) : '0;
      offy = o_cuse ? (o_negy ? -qys : qys) : '0;
    end
    sumx = {{2{center_x_q[W-1]}}, center_x_q} + offx;
    sumy = {{2{center_y_q[W-1]}}, center_y_q} + offy;
    priority if (sumx > sat_hi) px_d = sat_hi[W-1:0];
    else if (sumx < sat_lo)     px_d = sat_lo[W-1:0];
    else                        px_d = sumx[W-1:0];
    priority if (sumy > sat_hi) py_d = sat_hi[W-1:0];
    else if (sumy < sat_lo)     py_d = sat_lo[W-1:0];
    else                        py_d = sumy[W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      placed_x_q <= px_d;
      placed_y_q <= py_d;
      inside_q   <= o_inside;
    end
  end

  assign place_o.placed_x   = placed_x_q;
  assign place_o.placed_y   = placed_y_q;
  assign place_o.inside_res = inside_q;

endmodule

FILE: src/pcb_checker.sv
// Port-level assertions for the point clamp unit, bound to the top level.
`include "point_clamp_to_circle_or_box_unit_macros.svh"

module pcb_checker #(
  parameter int COORD_BITS = 16
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [COORD_BITS-1:0] placed_x_i,
  input logic [COORD_BITS-1:0] placed_y_i,
  input logic                  inside_i
);

  // once a reset edge has been seen, no result is pending
  `PCB_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |=> !out_valid_i, "result valid during reset")

  // input side stalls exactly when a result waits untaken
  `PCB_ASSERT(a_ready_follows_out, in_ready_i == (!out_valid_i || out_ready_i), "input ready mismatch")

  // untaken result holds its payload
  `PCB_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(placed_x_i) && $stable(placed_y_i) && $stable(inside_i), "stalled result changed")

  // no input is accepted while a result waits untaken
  `PCB_ASSERT(a_stall_blocks_in, out_valid_i && !out_ready_i |-> !(in_valid_i && in_ready_i), "input taken during stall")

endmodule

bind point_clamp_to_circle_or_box_unit pcb_checker #(.COORD_BITS(COORD_BITS)) u_pcb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (point_i.valid),
  .in_ready_i  (point_i.ready),
  .out_valid_i (place_o.valid),
  .out_ready_i (place_o.ready),
  .placed_x_i  (place_o.placed_x),
  .placed_y_i  (place_o.placed_y),
  .inside_i    (place_o.inside_res)
);

FILE: bench/testbench.sv
// Self-checking bench for the point clamp unit: box clamp and circle ring placement.
`timescale 1ns / 100ps

module testbench;

  localparam int  CW         = 16;
  localparam int  LATENCY    = CW + 45;
  localparam logic [pcb_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam longint COORD_MAX = 32767;
  localparam longint COORD_MIN = -32768;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 in_orb;
  } placed_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pcb_cfg_if   #(.W(CW)) cfg_bus ();
  pcb_point_if #(.W(CW)) pt_bus ();
  pcb_place_if #(.W(CW)) pl_bus ();

  point_clamp_to_circle_or_box_unit #(.COORD_BITS(CW)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .point_i(pt_bus),
    .place_o(pl_bus)
  );

  // shadow copy of the orbit registers
  logic signed [CW-1:0] orb_cx, orb_cy;
  logic [CW-2:0]        orb_hx, orb_hy;
  logic                 orb_box;

  placed_t placed_q[$];
  int      err_cnt = 0;
  bit      tx_idle_on = 1'b1;
  bit      rx_idle_on = 1'b1;
  int      hold_req = 0;
  int      hold_left = 0;
  int      rx_idle_left = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic longint unsigned round_div(longint unsigned num, longint unsigned den);
    return (num + den / 2) / den;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s  -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  function automatic longint signed_mag(longint ref_v, longint unsigned m);
    return ref_v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic placed_t place_point(logic signed [CW-1:0] px, logic signed [CW-1:0] py);
    placed_t res;
    longint dx, dy, ox, oy;
    longint unsigned ax, ay, hx, hy, r, sx, sy, s, root;
    int     f;
    bit     over, xdom, in_orb;
    dx = longint'(px) - longint'(orb_cx);
    dy = longint'(py) - longint'(orb_cy);
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    hx = orb_hx;
    hy = orb_hy;
    ox = 0;
    oy = 0;
    if (orb_box) begin
      over   = (hx > 0 && ax > hx) || (hy > 0 && ay > hy);
      in_orb = (ax <= hx) && (ay <= hy);
      if (hx == 0) xdom = 1'b0;
      else if (hy == 0) xdom = ax > 0;
      else xdom = ax * hy > ay * hx;
      ox = dx;
      oy = dy;
      if (over) begin
        if (xdom) begin
          ox = signed_mag(dx, hx);
          oy = signed_mag(dy, round_div(ay * hx, ax));
        end else begin
          oy = signed_mag(dy, hy);
          ox = signed_mag(dx, round_div(ax * hy, ay));
        end
      end
    end else begin
      r = hx < hy ? hx : hy;
      if (ax > r || ay > r) in_orb = 1'b0;
      else in_orb = ax * ax + ay * ay <= r * r;
      sx = ax;
      sy = ay;
      while (sx >= (64'd1 << 30) || sy >= (64'd1 << 30)) begin
        sx >>= 1;
        sy >>= 1;
      end
      s = sx * sx + sy * sy;
      f = 0;
      if (s != 0 && r != 0) begin
        while (s < (64'd1 << 60)) begin
          s <<= 2;
          f++;
        end
        root = int_sqrt(s);
        ox = signed_mag(dx, round_div((sx << f) * r, root));
        oy = signed_mag(dy, round_div((sy << f) * r, root));
      end
    end
    res.x      = CW'(clamp_coord(longint'(orb_cx) + ox));
    res.y      = CW'(clamp_coord(longint'(orb_cy) + oy));
    res.in_orb = in_orb;
    return res;
  endfunction

  // receiver: random short stalls plus an occasional long hold-off
  always @(negedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      pl_bus.ready = 1'b0;
    end else if (rx_idle_left > 0) begin
      rx_idle_left--;
      pl_bus.ready = 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
      rx_idle_left = $urandom_range(1, 4) - 1;
      pl_bus.ready = 1'b0;
    end else begin
      pl_bus.ready = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    placed_t exp_p;
    if (rst_ni && pl_bus.valid && pl_bus.ready) begin
      if (placed_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("ERROR: unexpected result x=%0d y=%0d inside=%0b",
                   pl_bus.placed_x, pl_bus.placed_y, pl_bus.inside_res);
      end else begin
        exp_p = placed_q.pop_front();
        if (pl_bus.placed_x !== exp_p.x || pl_bus.placed_y !== exp_p.y ||
            pl_bus.inside_res !== exp_p.in_orb) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("ERROR: expected x=%0d y=%0d inside=%0b, got x=%0d y=%0d inside=%0b",
                     exp_p.x, exp_p.y, exp_p.in_orb,
                     pl_bus.placed_x, pl_bus.placed_y, pl_bus.inside_res);
        end
      end
    end
  end

  // starts and ends at a falling edge; valid stays high for a back-to-back item
  task automatic send_point(logic signed [CW-1:0] px, logic signed [CW-1:0] py);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      pt_bus.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    pt_bus.valid   = 1'b1;
    pt_bus.point_x = px;
    pt_bus.point_y = py;
    do @(posedge clk_i); while (!pt_bus.ready);
    placed_q.push_back(place_point(px, py));
    @(negedge clk_i);
  endtask

  task automatic drain();
    pt_bus.valid = 1'b0;
    while (placed_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [pcb_pkg::CFG_IDX_W-1:0] idx, logic [CW-1:0] val);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = val;
    do @(posedge clk_i); while (!cfg_bus.ready);
    case (idx)
      pcb_pkg::REG_CENTER_X:    orb_cx = val;
      pcb_pkg::REG_CENTER_Y:    orb_cy = val;
      pcb_pkg::REG_HALF_X:      orb_hx = val[CW-2:0];
      pcb_pkg::REG_HALF_Y:      orb_hy = val[CW-2:0];
      pcb_pkg::REG_SQUARE_MODE: orb_box = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic set_orbit(logic signed [CW-1:0] cx, logic signed [CW-1:0] cy,
                           logic [CW-2:0] hx, logic [CW-2:0] hy, logic box);
    drain();
    write_reg(pcb_pkg::REG_CENTER_X, cx);
    write_reg(pcb_pkg::REG_CENTER_Y, cy);
    write_reg(pcb_pkg::REG_HALF_X, {1'b0, hx});
    write_reg(pcb_pkg::REG_HALF_Y, {1'b0, hy});
    write_reg(pcb_pkg::REG_SQUARE_MODE, {15'd0, box});
  endtask

  function automatic logic [CW-2:0] pick_half();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 15'h7fff;
      2: return 15'($urandom_range(1, 16));
      default: return 15'($urandom_range(1, 4000));
    endcase
  endfunction

  task automatic test_directed_box();
    set_orbit(0, 0, 160, 80, 1'b1);
    send_point(16, 16);
    send_point(160, -80);
    send_point(320, 0);
    send_point(-320, 160);
    send_point(-32768, -32768);
    send_point(32767, 32767);
    send_point(32767, -32768);
    send_point(320, 160);                // tie between axes
    set_orbit(0, 0, 0, 80, 1'b1);        // zero half width
    send_point(500, 40);
    send_point(500, 400);
    set_orbit(32767, -32768, 32767, 32767, 1'b1);
    send_point(-32768, 32767);
    send_point(32767, -32768);
  endtask

  task automatic test_directed_circle();
    set_orbit(0, 0, 160, 320, 1'b0);
    send_point(0, 0);                    // zero offset stays at center
    send_point(100, 100);
    send_point(160, 0);
    send_point(-32768, 32767);
    send_point(32767, -32768);
    set_orbit(100, 100, 0, 200, 1'b0);   // zero radius
    send_point(-500, 900);
    set_orbit(-32768, 32767, 32767, 32767, 1'b0);
    send_point(32767, -32768);
    send_point(-32768, 32767);
  endtask

  task automatic test_unknown_register();
    drain();
    write_reg(REG_UNUSED, 16'hffff);
    send_point(1234, -4321);
  endtask

  task automatic test_random(int n_points);
    logic signed [CW-1:0] px, py;
    longint spanx, spany;
    set_orbit(CW'($urandom), CW'($urandom), pick_half(), pick_half(),
              1'($urandom_range(0, 1)));
    spanx = 3 * longint'(orb_hx) + 8;
    spany = 3 * longint'(orb_hy) + 8;
    repeat (n_points) begin
      if ($urandom_range(0, 2) == 0) begin
        px = CW'($urandom);
        py = CW'($urandom);
      end else begin
        px = CW'(clamp_coord(longint'(orb_cx) + longint'($urandom_range(0, 2 * spanx)) - spanx));
        py = CW'(clamp_coord(longint'(orb_cy) + longint'($urandom_range(0, 2 * spany)) - spany));
      end
      send_point(px, py);
    end
  endtask

  task automatic test_backpressure();
    set_orbit(-200, 300, 500, 700, 1'b0);
    tx_idle_on = 1'b0;
    hold_req = 300;
    repeat (150) send_point(CW'($urandom), CW'($urandom));
    tx_idle_on = 1'b1;
    drain();                             // sender pauses for everything to come back
    repeat (20) send_point(CW'($urandom), CW'($urandom));
  endtask

  initial begin
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data  = '0;
    pt_bus.valid   = 1'b0;
    pt_bus.point_x = '0;
    pt_bus.point_y = '0;
    pl_bus.ready   = 1'b0;
    orb_cx = 0; orb_cy = 0; orb_hx = 0; orb_hy = 0; orb_box = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    send_point(200, -300);               // reset values: circle, zero radius
    test_directed_box();
    test_directed_circle();
    test_unknown_register();
    test_backpressure();
    repeat (12) test_random(130);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_random(120);
    drain();
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/pcb_pkg.sv
src/pcb_if.sv
src/pcb_delay.sv
src/pcb_isqrt.sv
src/pcb_div.sv
src/point_clamp_to_circle_or_box_unit.sv
src/pcb_checker.sv
bench/testbench.sv
